// ----- hw/rtl/eg_pkg.sv -----
package eg_pkg;

  localparam int FIELD_BITS = 32;
  localparam int ADDR_BITS  = 4;

  // Register indexes, byte address is 4 * index.
  localparam logic [1:0] REG_MODULUS     = 2'd0;
  localparam logic [1:0] REG_GENERATOR   = 2'd1;
  localparam logic [1:0] REG_PRIVATE_KEY = 2'd2;

  localparam logic [31:0] RESET_MODULUS     = 32'd23;
  localparam logic [31:0] RESET_GENERATOR   = 32'd5;
  localparam logic [31:0] RESET_PRIVATE_KEY = 32'd1;

  localparam logic OPER_ENCRYPT = 1'b0;
  localparam logic OPER_DECRYPT = 1'b1;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_CLEAR, OP_MUL, OP_POW_INIT, OP_POW_SHIFT, OP_SAVE,
    OP_INV_INIT, OP_DIV, OP_INV_STEP, OP_INV_DONE, OP_PUBLISH
  } dp_op_t;

  typedef enum logic [2:0] {A_ONE, A_PB, A_PACC, A_S, A_T1} asel_t;
  typedef enum logic [2:0] {B_GEN, B_Y, B_EKEY, B_PB, B_MSG, B_CIN, B_Q} bsel_t;
  typedef enum logic [2:0] {D_PB, D_PACC, D_PROD, D_CO, D_PO, D_Y, D_S, D_EKO} dst_t;
  typedef enum logic {E_PRIV, E_K} esel_t;

  typedef struct packed {
    dp_op_t op;
    asel_t  a_sel;
    bsel_t  b_sel;
    dst_t   dst;
    esel_t  e_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
    logic pe_lsb;
    logic r1_zero;
    logic p_zero;
    logic is_dec;
  } dp_sts_t;

  typedef struct packed {
    logic                  operation;
    logic [FIELD_BITS-1:0] message;
    logic [FIELD_BITS-1:0] ephemeral_exponent;
    logic [FIELD_BITS-1:0] ephemeral_key_in;
    logic [FIELD_BITS-1:0] cipher_in;
  } item_t;

  typedef struct packed {
    logic [FIELD_BITS-1:0] ephemeral_key_out;
    logic [FIELD_BITS-1:0] cipher_out;
    logic [FIELD_BITS-1:0] plain_out;
    logic                  message_too_large;
  } result_t;

endpackage

// ----- hw/rtl/eg_if.sv -----
interface eg_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [31:0] message;
  logic [31:0] ephemeral_exponent;
  logic [31:0] ephemeral_key_in;
  logic [31:0] cipher_in;

  modport source (output valid, operation, message, ephemeral_exponent, ephemeral_key_in,
                  cipher_in, input ready);
  modport sink (input valid, operation, message, ephemeral_exponent, ephemeral_key_in,
                cipher_in, output ready);
endinterface

interface eg_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] ephemeral_key_out;
  logic [31:0] cipher_out;
  logic [31:0] plain_out;
  logic        message_too_large;

  modport source (output valid, ephemeral_key_out, cipher_out, plain_out, message_too_large,
                  input ready);
  modport sink (input valid, ephemeral_key_out, cipher_out, plain_out, message_too_large,
                output ready);
endinterface

// ----- hw/rtl/eg_modmul.sv -----
module eg_modmul import eg_pkg::*; #(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic [W-1:0] m,
  output logic         done,
  output logic [W-1:0] prod
);

  localparam int CW = $clog2(W);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [W-1:0]  acc;
  logic [W-1:0]  ma;
  logic [W-1:0]  mb;
  logic [W+1:0]  sum;
  logic [W+1:0]  red1;
  logic [W+1:0]  red2;

  // Operand a is below m and so is acc, so 2*acc + a stays below 3m.
  always_comb begin
    sum  = {1'b0, acc, 1'b0} + (mb[W-1] ? {2'b00, ma} : '0);
    red1 = (sum >= {2'b00, m}) ? sum - {2'b00, m} : sum;
    red2 = (red1 >= {2'b00, m}) ? red1 - {2'b00, m} : red1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == '0);
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(W - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
        end
      end
    end
    if (start) begin
      acc <= '0;
      ma  <= a;
      mb  <= b;
    end else if (busy) begin
      acc <= red2[W-1:0];
      mb  <= {mb[W-2:0], 1'b0};
    end
  end

  assign prod = acc;

endmodule

// ----- hw/rtl/eg_datapath.sv -----
module eg_datapath import eg_pkg::*; #(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  dp_cmd_t      cmd,
  output dp_sts_t      sts,
  input  item_t        item,
  input  logic [W-1:0] modulus,
  input  logic [W-1:0] generator,
  input  logic [W-1:0] private_key,
  output result_t      result
);

  localparam int CW = $clog2(W);

  logic [W-1:0] msg, k, ekey, cin;
  logic         op_dec;
  logic [W-1:0] pb, pacc, pe, y, s, eko, co, po;
  logic         big;
  logic [W-1:0] r0, r1, t0, t1, prod;
  logic [W-1:0] one;
  logic [W-1:0] mul_a, mul_b, mul_prod;
  logic         mul_start, mul_done;
  dst_t         mul_dst;
  logic [W-1:0] t_next;

  logic          dv_busy, dv_done;
  logic [CW-1:0] dv_cnt;
  logic [W:0]    dv_rem;
  logic [W-1:0]  dv_q;
  logic [W:0]    dv_rem2;
  logic          dv_ge;

  assign one = (modulus == W'(1)) ? '0 : W'(1);

  always_comb begin
    case (cmd.a_sel)
      A_ONE:   mul_a = one;
      A_PB:    mul_a = pb;
      A_PACC:  mul_a = pacc;
      A_S:     mul_a = s;
      A_T1:    mul_a = t1;
      default: mul_a = one;
    endcase
    case (cmd.b_sel)
      B_GEN:   mul_b = generator;
      B_Y:     mul_b = y;
      B_EKEY:  mul_b = ekey;
      B_PB:    mul_b = pb;
      B_MSG:   mul_b = msg;
      B_CIN:   mul_b = cin;
      B_Q:     mul_b = dv_q;
      default: mul_b = generator;
    endcase
  end

  assign mul_start = (cmd.op == OP_MUL);

  eg_modmul #(.W(W)) u_modmul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .m     (modulus),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  // Restoring divider for the Euclid quotient r0 / r1.
  always_comb begin
    dv_rem2 = {dv_rem[W-1:0], dv_q[W-1]};
    dv_ge   = (dv_rem2 >= {1'b0, r1});
  end

  // (t0 - prod) mod m, both operands already reduced.
  assign t_next = t0 - prod + ((t0 < prod) ? modulus : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_busy <= 1'b0;
      dv_done <= 1'b0;
      dv_cnt  <= '0;
    end else begin
      dv_done <= dv_busy && (dv_cnt == '0);
      if (cmd.op == OP_DIV) begin
        dv_busy <= 1'b1;
        dv_cnt  <= CW'(W - 1);
      end else if (dv_busy) begin
        dv_cnt <= dv_cnt - 1'b1;
        if (dv_cnt == '0) begin
          dv_busy <= 1'b0;
        end
      end
    end
    if (cmd.op == OP_DIV) begin
      dv_rem <= '0;
      dv_q   <= r0;
    end else if (dv_busy) begin
      dv_rem <= dv_ge ? dv_rem2 - {1'b0, r1} : dv_rem2;
      dv_q   <= {dv_q[W-2:0], dv_ge};
    end
  end

  always_ff @(posedge clk) begin
    if (mul_start) begin
      mul_dst <= cmd.dst;
    end
    if (mul_done) begin
      case (mul_dst)
        D_PB:    pb   <= mul_prod;
        D_PACC:  pacc <= mul_prod;
        D_PROD:  prod <= mul_prod;
        D_CO:    co   <= mul_prod;
        D_PO:    po   <= mul_prod;
        D_Y:     y    <= mul_prod;
        D_S:     s    <= mul_prod;
        D_EKO:   eko  <= mul_prod;
        default: prod <= mul_prod;
      endcase
    end
    case (cmd.op)
      OP_LOAD: begin
        op_dec <= item.operation;
        msg    <= item.message[W-1:0];
        k      <= item.ephemeral_exponent[W-1:0];
        ekey   <= item.ephemeral_key_in[W-1:0];
        cin    <= item.cipher_in[W-1:0];
      end
      OP_CLEAR: begin
        eko <= '0;
        co  <= '0;
        po  <= '0;
        big <= (op_dec == OPER_ENCRYPT) && (msg >= modulus);
      end
      OP_POW_INIT: begin
        pacc <= one;
        pe   <= (cmd.e_sel == E_K) ? k : private_key;
      end
      OP_POW_SHIFT: pe <= pe >> 1;
      OP_SAVE: begin
        case (cmd.dst)
          D_Y:     y   <= pacc;
          D_S:     s   <= pacc;
          D_EKO:   eko <= pacc;
          default: s   <= pacc;
        endcase
      end
      OP_INV_INIT: begin
        r0 <= modulus;
        r1 <= s;
        t0 <= '0;
        t1 <= one;
      end
      OP_INV_STEP: begin
        r0 <= r1;
        r1 <= dv_rem[W-1:0];
        t0 <= t1;
        t1 <= t_next;
      end
      OP_INV_DONE: pacc <= (r0 == W'(1)) ? t0 : one;
      OP_PUBLISH: begin
        result.ephemeral_key_out <= FIELD_BITS'(eko);
        result.cipher_out        <= FIELD_BITS'(co);
        result.plain_out         <= FIELD_BITS'(po);
        result.message_too_large <= big;
      end
      default: ;
    endcase
  end

  always_comb begin
    sts.mul_done = mul_done;
    sts.div_done = dv_done;
    sts.pe_lsb   = pe[0];
    sts.r1_zero  = (r1 == '0);
    sts.p_zero   = (modulus == '0);
    sts.is_dec   = (op_dec == OPER_DECRYPT);
  end

endmodule

// ----- hw/rtl/eg_ctrl.sv -----
module eg_ctrl import eg_pkg::*; #(
  parameter int W = 32
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  localparam int CW = $clog2(W);

  typedef enum logic [4:0] {
    S_IDLE, S_CLEAR, S_POW_LOAD_GO, S_POW_LOAD_WAIT, S_POW_INIT, S_POW_BIT,
    S_POW_ACC_WAIT, S_POW_SQR_GO, S_POW_SQR_WAIT, S_POW_SHIFT, S_POW_RET,
    S_ENC_GO, S_ENC_WAIT, S_INV_INIT, S_INV_CHECK, S_DIV_GO, S_DIV_WAIT,
    S_IMUL_GO, S_IMUL_WAIT, S_INV_STEP, S_INV_DONE, S_DEC_GO, S_DEC_WAIT,
    S_PUBLISH
  } state_t;

  // Which exponentiation the shared power loop is running.
  typedef enum logic [1:0] {P_Y, P_SE, P_EKO, P_SD} pow_t;

  state_t        state;
  pow_t          pow_id;
  logic [CW-1:0] bit_cnt;
  bsel_t         pow_base;
  esel_t         pow_exp;
  dst_t          pow_dst;
  logic          publish;

  always_comb begin
    case (pow_id)
      P_Y:     begin pow_base = B_GEN;  pow_exp = E_PRIV; pow_dst = D_Y;   end
      P_SE:    begin pow_base = B_Y;    pow_exp = E_K;    pow_dst = D_S;   end
      P_EKO:   begin pow_base = B_GEN;  pow_exp = E_K;    pow_dst = D_EKO; end
      P_SD:    begin pow_base = B_EKEY; pow_exp = E_PRIV; pow_dst = D_S;   end
      default: begin pow_base = B_GEN;  pow_exp = E_PRIV; pow_dst = D_Y;   end
    endcase
  end

  assign publish  = (state == S_PUBLISH) && (!out_valid || out_ready);
  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd.op    = OP_NONE;
    cmd.a_sel = A_ONE;
    cmd.b_sel = B_GEN;
    cmd.dst   = D_PB;
    cmd.e_sel = pow_exp;
    case (state)
      S_IDLE:        if (in_valid) cmd.op = OP_LOAD;
      S_CLEAR:       cmd.op = OP_CLEAR;
      S_POW_LOAD_GO: begin
        cmd.op = OP_MUL; cmd.a_sel = A_ONE; cmd.b_sel = pow_base; cmd.dst = D_PB;
      end
      S_POW_INIT:    cmd.op = OP_POW_INIT;
      S_POW_BIT: begin
        if (sts.pe_lsb) begin
          cmd.op = OP_MUL; cmd.a_sel = A_PACC; cmd.b_sel = B_PB; cmd.dst = D_PACC;
        end
      end
      S_POW_SQR_GO: begin
        cmd.op = OP_MUL; cmd.a_sel = A_PB; cmd.b_sel = B_PB; cmd.dst = D_PB;
      end
      S_POW_SHIFT:   cmd.op = OP_POW_SHIFT;
      S_POW_RET: begin
        cmd.op = OP_SAVE; cmd.dst = pow_dst;
      end
      S_ENC_GO: begin
        cmd.op = OP_MUL; cmd.a_sel = A_S; cmd.b_sel = B_MSG; cmd.dst = D_CO;
      end
      S_INV_INIT:    cmd.op = OP_INV_INIT;
      S_DIV_GO:      cmd.op = OP_DIV;
      S_IMUL_GO: begin
        cmd.op = OP_MUL; cmd.a_sel = A_T1; cmd.b_sel = B_Q; cmd.dst = D_PROD;
      end
      S_INV_STEP:    cmd.op = OP_INV_STEP;
      S_INV_DONE:    cmd.op = OP_INV_DONE;
      S_DEC_GO: begin
        cmd.op = OP_MUL; cmd.a_sel = A_PACC; cmd.b_sel = B_CIN; cmd.dst = D_PO;
      end
      S_PUBLISH:     if (publish) cmd.op = OP_PUBLISH;
      default:       cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pow_id    <= P_Y;
      bit_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (publish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: if (in_valid) state <= S_CLEAR;
        S_CLEAR: begin
          if (sts.p_zero) begin
            state <= S_PUBLISH;
          end else begin
            pow_id <= sts.is_dec ? P_SD : P_Y;
            state  <= S_POW_LOAD_GO;
          end
        end
        S_POW_LOAD_GO:   state <= S_POW_LOAD_WAIT;
        S_POW_LOAD_WAIT: if (sts.mul_done) state <= S_POW_INIT;
        S_POW_INIT: begin
          bit_cnt <= '0;
          state   <= S_POW_BIT;
        end
        S_POW_BIT:      state <= sts.pe_lsb ? S_POW_ACC_WAIT : S_POW_SQR_GO;
        S_POW_ACC_WAIT: if (sts.mul_done) state <= S_POW_SQR_GO;
        S_POW_SQR_GO:   state <= S_POW_SQR_WAIT;
        S_POW_SQR_WAIT: if (sts.mul_done) state <= S_POW_SHIFT;
        S_POW_SHIFT: begin
          bit_cnt <= bit_cnt + 1'b1;
          state   <= (bit_cnt == CW'(W - 1)) ? S_POW_RET : S_POW_BIT;
        end
        S_POW_RET: begin
          case (pow_id)
            P_Y:     begin pow_id <= P_SE;  state <= S_POW_LOAD_GO; end
            P_SE:    begin pow_id <= P_EKO; state <= S_POW_LOAD_GO; end
            P_EKO:   state <= S_ENC_GO;
            P_SD:    state <= S_INV_INIT;
            default: state <= S_IDLE;
          endcase
        end
        S_ENC_GO:    state <= S_ENC_WAIT;
        S_ENC_WAIT:  if (sts.mul_done) state <= S_PUBLISH;
        S_INV_INIT:  state <= S_INV_CHECK;
        S_INV_CHECK: state <= sts.r1_zero ? S_INV_DONE : S_DIV_GO;
        S_DIV_GO:    state <= S_DIV_WAIT;
        S_DIV_WAIT:  if (sts.div_done) state <= S_IMUL_GO;
        S_IMUL_GO:   state <= S_IMUL_WAIT;
        S_IMUL_WAIT: if (sts.mul_done) state <= S_INV_STEP;
        S_INV_STEP:  state <= S_INV_CHECK;
        S_INV_DONE:  state <= S_DEC_GO;
        S_DEC_GO:    state <= S_DEC_WAIT;
        S_DEC_WAIT:  if (sts.mul_done) state <= S_PUBLISH;
        S_PUBLISH:   if (publish) state <= S_IDLE;
        default:     state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- hw/rtl/elgamal_cipher_unit.sv -----
// At WORD_BITS = 32, encrypt runs three 32-bit exponentiations.
// Decrypt runs one exponentiation plus up to ~46 Euclid rounds.
// Each exponentiation is paced by the single bit-serial modular
// multiplier; a zero modulus skips straight to the result. One item is worked at a time and
// the next one is accepted as soon as the result sits in the output register.
// Reset: synchronous; registers return to modulus 23, generator 5, private key 1.
module elgamal_cipher_unit import eg_pkg::*; #(
  parameter int WORD_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  eg_in_if.sink                in_ch,
  eg_out_if.source             out_ch,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  // Configuration registers, held at WORD_BITS; upper data bits are dropped.
  logic [WORD_BITS-1:0] modulus;
  logic [WORD_BITS-1:0] generator;
  logic [WORD_BITS-1:0] private_key;
  logic [1:0]           reg_idx;
  logic                 cfg_write;

  dp_cmd_t cmd;
  dp_sts_t sts;
  item_t   item;
  result_t result;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[3:2];
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus     <= WORD_BITS'(RESET_MODULUS);
      generator   <= WORD_BITS'(RESET_GENERATOR);
      private_key <= WORD_BITS'(RESET_PRIVATE_KEY);
    end else if (cfg_write) begin
      case (reg_idx)
        REG_MODULUS:     modulus     <= pwdata[WORD_BITS-1:0];
        REG_GENERATOR:   generator   <= pwdata[WORD_BITS-1:0];
        REG_PRIVATE_KEY: private_key <= pwdata[WORD_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_MODULUS:     prdata = 32'(modulus);
      REG_GENERATOR:   prdata = 32'(generator);
      REG_PRIVATE_KEY: prdata = 32'(private_key);
      default:         prdata = '0;
    endcase
  end

  // The input transaction is captured into the datapath when the controller is idle.
  always_comb begin
    item.operation          = in_ch.operation;
    item.message            = in_ch.message;
    item.ephemeral_exponent = in_ch.ephemeral_exponent;
    item.ephemeral_key_in   = in_ch.ephemeral_key_in;
    item.cipher_in          = in_ch.cipher_in;
  end

  eg_ctrl #(.W(WORD_BITS)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  eg_datapath #(.W(WORD_BITS)) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .item        (item),
    .modulus     (modulus),
    .generator   (generator),
    .private_key (private_key),
    .result      (result)
  );

  // The output register holds the finished transaction until the sink takes it.
  assign out_ch.ephemeral_key_out = result.ephemeral_key_out;
  assign out_ch.cipher_out        = result.cipher_out;
  assign out_ch.plain_out         = result.plain_out;
  assign out_ch.message_too_large = result.message_too_large;

`ifndef SYNTHESIS
  // Once a transaction is taken, the unit is not ready again in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input accepted again right after a transaction");

  // Loading the output register always presents a result.
  a_publish_valid: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_PUBLISH) |=> out_ch.valid)
    else $error("published result not presented");

  // The oversize flag only comes from an encrypt, which leaves plain_out at zero.
  a_flag_encrypt_only: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.message_too_large) |-> (out_ch.plain_out == '0))
    else $error("oversize flag on a decrypt result");
`endif

endmodule
